// ===== design/erv_pkg.sv =====
package erv_pkg;

   // Default field widths.
   localparam int COORD_BITS_DEF = 16;
   localparam int ANGLE_BITS_DEF = 16;

   // Sine polynomial coefficients, Q15.
   localparam logic [15:0] SIN_A = 16'd51472;
   localparam logic [15:0] SIN_B = 16'd21024;
   localparam logic [11:0] SIN_C = 12'd2320;

   // 1/sqrt(3) in Q16.
   localparam logic [15:0] INV_SQRT3_Q16 = 16'd37837;

   // Reset value of the height register, about 0.66 in Q12.
   localparam int HEIGHT_RESET = 2703;

   // Sine/cosine width (signed Q15, covers +1.0) and rotation entry width.
   localparam int SIN_W = 18;
   localparam int R_W   = 19;

   // Front pipeline depth: four sine stages and two matrix stages.
   localparam int FRONT_DEPTH = 6;

   // Register indexes.
   localparam logic REG_HEIGHT = 1'b0;

   // Vertex indexes.
   localparam logic [1:0] VTX_TOP         = 2'd0;
   localparam logic [1:0] VTX_LOWER_LEFT  = 2'd1;
   localparam logic [1:0] VTX_LOWER_RIGHT = 2'd2;

   // Rotation matrix: the two columns that multiply the local x and y.
   typedef struct packed {
      logic signed [R_W-1:0] r00;
      logic signed [R_W-1:0] r01;
      logic signed [R_W-1:0] r10;
      logic signed [R_W-1:0] r11;
      logic signed [R_W-1:0] r20;
      logic signed [R_W-1:0] r21;
   } rot_type;

   // Product of two Q15 values back to Q15, rounded half away from zero.
   function automatic logic signed [SIN_W-1:0] round_q15(
      input logic signed [2*SIN_W-1:0] p
   );
      logic signed [2*SIN_W-1:0] bias;
      logic signed [2*SIN_W-1:0] q;
      bias = p[2*SIN_W-1] ? (2*SIN_W)'(16383) : (2*SIN_W)'(16384);
      q = (p + bias) >>> 15;
      return SIN_W'(q);
   endfunction

endpackage

// ===== design/euler_rotated_triangle_vertices.sv =====
// Euler-rotated triangle vertex generator. Each request transaction carries a
// triangle center and three Euler angles (fractions of a full turn); the block
// builds an equilateral-style triangle of the programmed height in the z=0
// plane, rotates it by Rx*Ry*Rz, offsets it by the center and returns three
// response transactions: top, lower left and lower right vertex, the last one
// with tlast set. Coordinates are signed Q.12 and saturate. New triangles are
// taken while earlier ones are still in flight, but the front stalls while
// the vertices of its oldest triangle are issued, because one set of six
// vertex multipliers is shared by the three vertices of a triangle. The height
// register lives at byte address 0 of the register port and should only be
// written while no triangle is in flight.
module euler_rotated_triangle_vertices
   import erv_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   // Request: center_x, center_y, center_z, angle_x, angle_y, angle_z,
   // from the lowest bit up, zero padded to whole bytes.
   input  logic [((3*COORD_BITS+3*ANGLE_BITS+7)/8)*8-1:0] req_tdata,
   input  logic req_tvalid,
   output logic req_tready,
   // Response: vertex_x, vertex_y, vertex_z, from the lowest bit up,
   // zero padded to whole bytes.
   output logic [((3*COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   // Response user field: vertex_index.
   output logic [1:0] rsp_tuser,
   output logic rsp_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // Register port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int HW     = COORD_BITS - 1;
   localparam int NW     = COORD_BITS;
   localparam int OUT_TW = ((3*COORD_BITS + 7) / 8) * 8;
   localparam int CTR_W  = 3 * COORD_BITS;
   // Reciprocal of three, rounded down, so the quotient estimate is never high.
   localparam logic [NW-1:0] RECIP3 = NW'((64'd1 << NW) / 64'd3);

   // ---------------------------------------------------------------------
   // Register port. The height register is the only one; the derived
   // third, two thirds and half base are recomputed every cycle from it.
   // ---------------------------------------------------------------------
   logic [HW-1:0] height_ff;
   logic          csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_HEIGHT) ? 32'(height_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= HW'(HEIGHT_RESET);
      end else if (csr_write && csr_paddr[2] == REG_HEIGHT) begin
         height_ff <= csr_pwdata[HW-1:0];
      end
   end

   // Division by three: estimate with the reciprocal, then correct once
   // using the remainder, which stays below six.
   logic [NW-1:0]   n1, n2;
   logic [2*NW-1:0] q1_prod, q2_prod;
   logic [NW-1:0]   q1_ff, q2_ff;
   logic [2:0]      r1, r2;
   logic [HW+15:0]  hb_prod;
   logic [HW-1:0]   hb_stage_ff;
   logic [HW-1:0]   third_ff, two_third_ff, half_base_ff;
   logic [HW-1:0]   third_in, two_third_in;

   always_comb begin
      n1      = NW'(height_ff) + NW'(1);
      n2      = {height_ff, 1'b1};
      q1_prod = (2*NW)'(n1) * (2*NW)'(RECIP3);
      q2_prod = (2*NW)'(n2) * (2*NW)'(RECIP3);
      hb_prod = (HW+16)'(height_ff) * (HW+16)'(INV_SQRT3_Q16) + (HW+16)'(32768);
      r1 = n1[2:0] - 3'({q1_ff[1:0], 1'b0} + q1_ff[2:0]);
      r2 = n2[2:0] - 3'({q2_ff[1:0], 1'b0} + q2_ff[2:0]);
      third_in     = (r1 >= 3'd3) ? HW'(q1_ff + NW'(1)) : HW'(q1_ff);
      two_third_in = (r2 >= 3'd3) ? HW'(q2_ff + NW'(1)) : HW'(q2_ff);
   end

   always_ff @(posedge clock) begin
      q1_ff        <= q1_prod[2*NW-1:NW];
      q2_ff        <= q2_prod[2*NW-1:NW];
      hb_stage_ff  <= hb_prod[HW+15:16];
      third_ff     <= third_in;
      two_third_ff <= two_third_in;
      half_base_ff <= hb_stage_ff;
   end

   // ---------------------------------------------------------------------
   // Front pipeline: four stages of sine/cosine, two stages of matrix
   // entries. It moves as one; it stalls only while its last stage holds a
   // triangle whose vertices have not all been issued.
   // ---------------------------------------------------------------------
   logic [FRONT_DEPTH-1:0] front_valid_ff;
   logic [CTR_W-1:0]       ctr_ff [FRONT_DEPTH];
   logic                   front_en;
   logic                   vtx_done;
   logic signed [SIN_W-1:0] sx, cx, sy, cy, sz, cz;
   rot_type                rot;

   assign front_en   = !front_valid_ff[FRONT_DEPTH-1] || vtx_done;
   assign req_tready = front_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= '0;
      end else if (front_en) begin
         front_valid_ff <= {front_valid_ff[FRONT_DEPTH-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         ctr_ff[0] <= req_tdata[CTR_W-1:0];
         for (int s = 1; s < FRONT_DEPTH; s++) begin
            ctr_ff[s] <= ctr_ff[s-1];
         end
      end
   end

   erv_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sincos_x (
      .clock    (clock),
      .en       (front_en),
      .angle_in (req_tdata[CTR_W +: ANGLE_BITS]),
      .sin_out  (sx),
      .cos_out  (cx)
   );

   erv_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sincos_y (
      .clock    (clock),
      .en       (front_en),
      .angle_in (req_tdata[CTR_W+ANGLE_BITS +: ANGLE_BITS]),
      .sin_out  (sy),
      .cos_out  (cy)
   );

   erv_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sincos_z (
      .clock    (clock),
      .en       (front_en),
      .angle_in (req_tdata[CTR_W+2*ANGLE_BITS +: ANGLE_BITS]),
      .sin_out  (sz),
      .cos_out  (cz)
   );

   erv_matrix u_matrix (
      .clock   (clock),
      .en      (front_en),
      .sx      (sx),
      .cx      (cx),
      .sy      (sy),
      .cy      (cy),
      .sz      (sz),
      .cz      (cz),
      .rot_out (rot)
   );

   // ---------------------------------------------------------------------
   // Vertex sequencer: one vertex per cycle unless stalled, through a product
   // stage and a round, offset and saturate stage into the response register.
   // ---------------------------------------------------------------------
   logic [CTR_W-1:0] out_xyz;

   erv_vertex #(.COORD_BITS(COORD_BITS)) u_vertex (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid_ff[FRONT_DEPTH-1]),
      .rot       (rot),
      .ctr       (ctr_ff[FRONT_DEPTH-1]),
      .third     (third_ff),
      .two_third (two_third_ff),
      .half_base (half_base_ff),
      .in_done   (vtx_done),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_xyz   (out_xyz),
      .out_index (rsp_tuser),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = OUT_TW'(out_xyz);

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   a_last_is_lower_right: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser == VTX_LOWER_RIGHT))
      else $error("tlast on a vertex other than the lower right one");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> front_valid_ff[FRONT_DEPTH-1])
      else $error("request side stalled with an empty last front stage");

   a_hold_keeps_triangle: assert property (@(posedge clock) disable iff (reset)
      (front_valid_ff[FRONT_DEPTH-1] && !front_en) |=> front_valid_ff[FRONT_DEPTH-1])
      else $error("held triangle dropped from the front pipeline");

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

// ===== design/erv_sincos.sv =====
module erv_sincos
   import erv_pkg::*;
#(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [ANGLE_BITS-1:0]   angle_in,
   output logic signed [SIN_W-1:0] sin_out,
   output logic signed [SIN_W-1:0] cos_out
);

   // Lane 0 computes the sine, lane 1 the cosine (phase plus a quarter turn).
   logic [31:0] phase;
   logic [1:0]  quad [2];
   logic [15:0] x_raw;
   logic [15:0] xm_in [2];
   logic [31:0] sq [2];
   logic [27:0] cx2 [2];
   logic [31:0] dx [2];
   logic [31:0] ex [2];

   logic [15:0] x1_ff [2], x2a_ff [2], x3_ff [2];
   logic [15:0] sq1_ff [2], sq2_ff [2];
   logic [15:0] t1_ff [2], t_ff [2];
   logic        neg1_ff [2], neg2_ff [2], neg3_ff [2];
   logic signed [SIN_W-1:0] s_ff [2];
   logic [15:0] t1_in [2], t_in [2];
   logic signed [SIN_W-1:0] s_in [2];

   always_comb begin
      phase   = 32'(angle_in) << (32 - ANGLE_BITS);
      quad[0] = phase[31:30];
      quad[1] = phase[31:30] + 2'd1;
      x_raw   = {1'b0, phase[29:15]};
      for (int j = 0; j < 2; j++) begin
         xm_in[j] = quad[j][0] ? 16'(17'd32768 - 17'(x_raw)) : x_raw;
         sq[j]    = xm_in[j] * xm_in[j];
         cx2[j]   = SIN_C * sq1_ff[j];
         t1_in[j] = SIN_B - 16'(cx2[j][27:15]);
         dx[j]    = sq2_ff[j] * t1_ff[j];
         t_in[j]  = SIN_A - 16'(dx[j][31:15]);
         ex[j]    = x3_ff[j] * t_ff[j];
         s_in[j]  = neg3_ff[j] ? -SIN_W'({1'b0, ex[j][31:15]})
                               :  SIN_W'({1'b0, ex[j][31:15]});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 2; j++) begin
            x1_ff[j]   <= xm_in[j];
            sq1_ff[j]  <= sq[j][30:15];
            neg1_ff[j] <= quad[j][1];
            x2a_ff[j]  <= x1_ff[j];
            sq2_ff[j]  <= sq1_ff[j];
            t1_ff[j]   <= t1_in[j];
            neg2_ff[j] <= neg1_ff[j];
            x3_ff[j]   <= x2a_ff[j];
            t_ff[j]    <= t_in[j];
            neg3_ff[j] <= neg2_ff[j];
            s_ff[j]    <= s_in[j];
         end
      end
   end

   assign sin_out = s_ff[0];
   assign cos_out = s_ff[1];

endmodule

// ===== design/erv_matrix.sv =====
module erv_matrix
   import erv_pkg::*;
(
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [SIN_W-1:0] sx,
   input  logic signed [SIN_W-1:0] cx,
   input  logic signed [SIN_W-1:0] sy,
   input  logic signed [SIN_W-1:0] cy,
   input  logic signed [SIN_W-1:0] sz,
   input  logic signed [SIN_W-1:0] cz,
   output rot_type                 rot_out
);

   logic signed [SIN_W-1:0] sxy_ff, cxy_ff, cycz_ff, cysz_ff;
   logic signed [SIN_W-1:0] cxsz_ff, cxcz_ff, sxsz_ff, sxcz_ff;
   logic signed [SIN_W-1:0] sz_ff, cz_ff;
   logic signed [SIN_W-1:0] m1, m2, m3, m4;
   rot_type rot_in, rot_ff;

   // Second stage: three-factor terms and the sums of each entry.
   always_comb begin
      m1 = round_q15(sxy_ff * cz_ff);
      m2 = round_q15(sxy_ff * sz_ff);
      m3 = round_q15(cxy_ff * cz_ff);
      m4 = round_q15(cxy_ff * sz_ff);
      rot_in.r00 = R_W'(cycz_ff);
      rot_in.r01 = -R_W'(cysz_ff);
      rot_in.r10 = R_W'(cxsz_ff) + R_W'(m1);
      rot_in.r11 = R_W'(cxcz_ff) - R_W'(m2);
      rot_in.r20 = R_W'(sxsz_ff) - R_W'(m3);
      rot_in.r21 = R_W'(sxcz_ff) + R_W'(m4);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sxy_ff  <= round_q15(sx * sy);
         cxy_ff  <= round_q15(cx * sy);
         cycz_ff <= round_q15(cy * cz);
         cysz_ff <= round_q15(cy * sz);
         cxsz_ff <= round_q15(cx * sz);
         cxcz_ff <= round_q15(cx * cz);
         sxsz_ff <= round_q15(sx * sz);
         sxcz_ff <= round_q15(sx * cz);
         sz_ff   <= sz;
         cz_ff   <= cz;
         rot_ff  <= rot_in;
      end
   end

   assign rot_out = rot_ff;

endmodule

// ===== design/erv_vertex.sv =====
module erv_vertex
   import erv_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  rot_type                      rot,
   input  logic [3*COORD_BITS-1:0]      ctr,
   input  logic [COORD_BITS-2:0]        third,
   input  logic [COORD_BITS-2:0]        two_third,
   input  logic [COORD_BITS-2:0]        half_base,
   output logic                         in_done,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [3*COORD_BITS-1:0]      out_xyz,
   output logic [1:0]                   out_index,
   output logic                         out_last
);

   localparam int ACC_W = R_W + COORD_BITS + 1;
   localparam logic signed [ACC_W:0] MAXV =
      (ACC_W+1)'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam logic signed [ACC_W:0] MINV = -MAXV - (ACC_W+1)'(1);

   logic [1:0] k_ff, k_in;
   logic       p_valid_ff, o_valid_ff;
   logic       p_ready, o_ready, issue;
   logic signed [COORD_BITS-1:0] lx, ly;
   logic signed [ACC_W-1:0] acc_in [3];
   logic signed [ACC_W-1:0] acc_ff [3];
   logic [3*COORD_BITS-1:0] pctr_ff;
   logic [1:0]              pk_ff;
   logic signed [ACC_W-1:0] bias [3];
   logic signed [ACC_W-1:0] rs [3];
   logic signed [ACC_W:0]   sum [3];
   logic [3*COORD_BITS-1:0] xyz_in, xyz_ff;
   logic [1:0]              idx_ff;
   logic                    last_ff;

   assign o_ready = !o_valid_ff || out_ready;
   assign p_ready = !p_valid_ff || o_ready;
   assign issue   = in_valid && p_ready;
   assign in_done = issue && (k_ff == VTX_LOWER_RIGHT);
   assign k_in    = (k_ff == VTX_LOWER_RIGHT) ? VTX_TOP : k_ff + 2'd1;

   always_comb begin
      case (k_ff)
         VTX_TOP: begin
            lx = '0;
            ly = signed'({1'b0, two_third});
         end
         VTX_LOWER_LEFT: begin
            lx = -signed'({1'b0, half_base});
            ly = -signed'({1'b0, third});
         end
         default: begin
            lx = signed'({1'b0, half_base});
            ly = -signed'({1'b0, third});
         end
      endcase
      acc_in[0] = ACC_W'(rot.r00 * lx) + ACC_W'(rot.r01 * ly);
      acc_in[1] = ACC_W'(rot.r10 * lx) + ACC_W'(rot.r11 * ly);
      acc_in[2] = ACC_W'(rot.r20 * lx) + ACC_W'(rot.r21 * ly);
   end

   // Round Q27 to Q12 half away from zero, add the center, saturate.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         bias[i] = acc_ff[i][ACC_W-1] ? ACC_W'(16383) : ACC_W'(16384);
         rs[i]   = (acc_ff[i] + bias[i]) >>> 15;
         sum[i]  = (ACC_W+1)'(rs[i])
                 + (ACC_W+1)'(signed'(pctr_ff[i*COORD_BITS +: COORD_BITS]));
         if (sum[i] > MAXV) begin
            xyz_in[i*COORD_BITS +: COORD_BITS] = COORD_BITS'(MAXV);
         end else if (sum[i] < MINV) begin
            xyz_in[i*COORD_BITS +: COORD_BITS] = COORD_BITS'(MINV);
         end else begin
            xyz_in[i*COORD_BITS +: COORD_BITS] = COORD_BITS'(sum[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff       <= VTX_TOP;
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (issue) begin
            k_ff <= k_in;
         end
         if (p_ready) begin
            p_valid_ff <= in_valid;
         end
         if (o_ready) begin
            o_valid_ff <= p_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         for (int i = 0; i < 3; i++) begin
            acc_ff[i] <= acc_in[i];
         end
         pctr_ff <= ctr;
         pk_ff   <= k_ff;
      end
      if (o_ready && p_valid_ff) begin
         xyz_ff  <= xyz_in;
         idx_ff  <= pk_ff;
         last_ff <= (pk_ff == VTX_LOWER_RIGHT);
      end
   end

   assign out_valid = o_valid_ff;
   assign out_xyz   = xyz_ff;
   assign out_index = idx_ff;
   assign out_last  = last_ff;

endmodule

// ===== tb/testbench.sv =====
module testbench;
   import erv_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Stimulus and checking for the Euler-rotated triangle vertex generator.
   // A request transaction carries a center and three angles; the predictor below
   // recomputes the rotation in integer arithmetic and queues three expected vertex
   // transactions, which a separate process compares against every response.

   localparam int DATA_W = 96;
   localparam int RSP_W  = 48;
   localparam int LIMIT  = 20000;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic [1:0]         index;
      logic               last;
   } vertex_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [DATA_W-1:0] req_tdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast, rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   // Mode of the idle generators: 0 sender 17% / receiver 57%, 1 swapped, 2 none.
   int idle_mode = 0;
   bit rsp_hold = 1'b0;
   int mismatches = 0;
   int idle_cycles = 0;
   logic [14:0] height_q12 = 15'(HEIGHT_RESET);
   vertex_t expected_vertices[$];

   euler_rotated_triangle_vertices dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Sine in Q15 from a 32-bit phase: odd polynomial per quadrant.
   function automatic longint sine_q15(logic [31:0] ph);
      longint x, x2, t, s;
      x = longint'(ph[29:15]);
      if (ph[30]) x = 32768 - x;
      x2 = (x * x) >>> 15;
      t = 21024 - ((2320 * x2) >>> 15);
      t = 51472 - ((x2 * t) >>> 15);
      s = (x * t) >>> 15;
      return ph[31] ? -s : s;
   endfunction

   function automatic longint round_away(longint v, int s);
      longint half;
      half = longint'(1) << (s - 1);
      if (v >= 0) return (v + half) >>> s;
      return -((-v + half) >>> s);
   endfunction

   function automatic longint mul_q15(longint a, longint b);
      return round_away(a * b, 15);
   endfunction

   function automatic logic signed [15:0] clamp_coord(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return -16'sh8000;
      return 16'(v);
   endfunction

   // Work out the three vertices of one triangle and queue them.
   task automatic predict_triangle(logic [DATA_W-1:0] d);
      longint ctr[3], lx[3], ly[3], rot[3][2];
      longint sx, cx, sy, cy, sz, cz, sxy, cxy, h, base, acc;
      logic [31:0] px, py, pz;
      logic signed [15:0] coord[3];
      vertex_t v;
      for (int i = 0; i < 3; i++) ctr[i] = longint'($signed(d[16*i +: 16]));
      px = {d[48 +: 16], 16'h0};
      py = {d[64 +: 16], 16'h0};
      pz = {d[80 +: 16], 16'h0};
      sx = sine_q15(px); cx = sine_q15(px + 32'h4000_0000);
      sy = sine_q15(py); cy = sine_q15(py + 32'h4000_0000);
      sz = sine_q15(pz); cz = sine_q15(pz + 32'h4000_0000);
      sxy = mul_q15(sx, sy);
      cxy = mul_q15(cx, sy);
      rot[0][0] = mul_q15(cy, cz);
      rot[0][1] = -mul_q15(cy, sz);
      rot[1][0] = mul_q15(cx, sz) + mul_q15(sxy, cz);
      rot[1][1] = mul_q15(cx, cz) - mul_q15(sxy, sz);
      rot[2][0] = mul_q15(sx, sz) - mul_q15(cxy, cz);
      rot[2][1] = mul_q15(sx, cz) + mul_q15(cxy, sz);
      h = longint'(height_q12);
      base = (h * 37837 + 32768) >>> 16;
      lx[0] = 0;     ly[0] = (2 * h + 1) / 3;
      lx[1] = -base; ly[1] = -((h + 1) / 3);
      lx[2] = base;  ly[2] = -((h + 1) / 3);
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            acc = rot[i][0] * lx[k] + rot[i][1] * ly[k];
            coord[i] = clamp_coord(round_away(acc, 15) + ctr[i]);
         end
         v.x = coord[0]; v.y = coord[1]; v.z = coord[2];
         v.index = (k == 0) ? VTX_TOP : (k == 1) ? VTX_LOWER_LEFT : VTX_LOWER_RIGHT;
         v.last = (k == 2);
         expected_vertices.push_back(v);
      end
   endtask

   // Send one request transaction, with a random idle gap before it when the
   // current mode lets the sender idle. Valid stays high after the handshake
   // so that back-to-back transactions need no gap; drain() drops it.
   task automatic send_triangle(logic [15:0] cx_, cy_, cz_, ax, ay, az);
      int pct;
      pct = (idle_mode == 0) ? 17 : (idle_mode == 1) ? 57 : 0;
      while ($urandom_range(99) < pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata <= {az, ay, ax, cz_, cy_, cx_};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_triangle(req_tdata);
   endtask

   task automatic send_random_triangle();
      send_triangle(16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // Wait until every expected vertex has arrived, plus the pipeline latency.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_vertices.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_height(logic [14:0] value);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {REG_HEIGHT, 2'b00}; csr_pwdata <= {17'h1abcd, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      height_q12 = value;
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Extreme centers, quadrant boundaries of each angle, and saturation.
   task automatic test_directed();
      send_triangle(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
      send_triangle(16'h7fff, 16'h7fff, 16'h7fff, 16'h0, 16'h0, 16'h0);
      send_triangle(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_triangle(16'h0, 16'h0, 16'h0, 16'h4000, 16'h0, 16'h0);
      send_triangle(16'h0, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h0);
      send_triangle(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h4000);
      send_triangle(16'h0, 16'h0, 16'h0, 16'hc000, 16'hc000, 16'hc000);
      send_triangle(16'h0, 16'h0, 16'h0, 16'hffff, 16'hffff, 16'hffff);
      send_triangle(16'h7ff0, 16'h8010, 16'h7ff0, 16'h2000, 16'h6000, 16'ha000);
      send_triangle(16'h8001, 16'h7ffe, 16'h8001, 16'h1234, 16'h5678, 16'h9abc);
      drain();
   endtask

   task automatic test_height_settings();
      logic [14:0] heights[4] = '{15'h7fff, 15'h0000, 15'h0001, 15'h4000};
      foreach (heights[i]) begin
         write_height(heights[i]);
         send_triangle(16'h7fff, 16'h8000, 16'h0, 16'h1000, 16'h2000, 16'h3000);
         send_triangle(16'h8000, 16'h7fff, 16'h0fff, 16'hffff, 16'h0, 16'h8000);
         repeat (4) send_random_triangle();
         drain();
      end
   endtask

   // Random items across the three idle modes, each under its own height.
   task automatic test_random_traffic();
      for (int m = 0; m < 3; m++) begin
         idle_mode = m;
         write_height(15'($urandom));
         repeat (25) send_random_triangle();
         drain();
      end
   endtask

   // The receiver holds off for a long stretch while requests keep coming.
   task automatic test_backpressure();
      idle_mode = 2;
      rsp_hold = 1'b1;
      fork
         repeat (12) send_random_triangle();
         begin
            repeat (200) @(posedge clock);
            rsp_hold = 1'b0;
         end
      join
      drain();
   endtask

   // Receiver idling.
   always @(posedge clock) begin
      int pct;
      pct = (idle_mode == 0) ? 57 : (idle_mode == 1) ? 17 : 0;
      rsp_tready <= !reset && !rsp_hold && ($urandom_range(99) >= pct);
   end

   // Compare each response transaction with the oldest expected vertex.
   always @(posedge clock) begin
      vertex_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32], rsp_tuser, rsp_tlast};
         if (expected_vertices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected vertex %p", got);
         end else begin
            want = expected_vertices.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("Vertex mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   // Watchdog on cycles where neither side completes a transaction.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_height_settings();
      test_backpressure();
      test_random_traffic();
      if (mismatches == 0 && expected_vertices.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
